// ===== src/stable_priority_queue_insert_defines.svh =====
// ----------------------------------------------------------------------------
// stable_priority_queue_insert_defines
// Assertion macros used by the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_INSERT_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_INSERT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check with reset masked
`define SPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check that also runs during reset
`define SPQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPQ_ASSERT(name, prop, msg)
`define SPQ_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  // queue size and derived widths
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int PRIO_W      = 8;
  localparam int TAG_W       = 16;
  localparam int STATUS_W    = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // request codes
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_READOUT = 1'b1;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  // command broadcast along the cell chain
  typedef struct packed {
    logic              insert;
    logic              rotate;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } chain_cmd_t;

endpackage

// ===== src/stable_priority_queue_insert.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_insert
// Stable sorted-insertion priority queue built as a chain of entry cells.
// ----------------------------------------------------------------------------
// On an insert request every cell compares its entry with the
// new priority at once and the chain shifts, so inserts can be accepted on
// consecutive cycles while results are taken. Each insert returns one word
// echoing the entry, with status full when the queue already holds
// QUEUE_DEPTH entries (the entry is then dropped). A readout of n stored
// entries gives no word for the request itself, then one word per cycle while
// results are taken, as the valid part of the chain rotates through the head
// cell; the queue is unchanged afterwards. No request is taken while a readout
// streams. A readout of an empty queue gives one word with status empty.
`timescale 1ns / 1ps

module stable_priority_queue_insert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [spq_pkg::PRIO_W-1:0]    item_priority_i,
  input  logic [spq_pkg::TAG_W-1:0]     item_tag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority_o,
  output logic [spq_pkg::TAG_W-1:0]     out_tag_o,
  output logic [spq_pkg::STATUS_W-1:0]  status_o,
  output logic                          last_o
);
  import spq_pkg::*;

  chain_cmd_t        cmd;
  logic [CNT_W-1:0]  cnt;
  logic [PRIO_W-1:0] prio_w [QUEUE_DEPTH];
  logic [TAG_W-1:0]  tag_w  [QUEUE_DEPTH];
  logic              keep_w [QUEUE_DEPTH];
  logic              valid_w [QUEUE_DEPTH];

  // sequencing and output register
  spq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .item_priority_i(item_priority_i),
    .item_tag_i     (item_tag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_priority_o (out_priority_o),
    .out_tag_o      (out_tag_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .head_prio_i    (prio_w[0]),
    .head_tag_i     (tag_w[0]),
    .cmd_o          (cmd),
    .cnt_o          (cnt)
  );

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic              keep_left;
    logic              next_valid;
    logic [PRIO_W-1:0] left_prio, right_prio;
    logic [TAG_W-1:0]  left_tag, right_tag;

    // occupied slots form a run from the head
    assign valid_w[i] = (CNT_W'(i) < cnt);

    if (i == 0) begin : g_head
      assign keep_left = 1'b1;
      assign left_prio = prio_w[0];
      assign left_tag  = tag_w[0];
    end else begin : g_body
      assign keep_left = keep_w[i-1];
      assign left_prio = prio_w[i-1];
      assign left_tag  = tag_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign right_prio = prio_w[0];
      assign right_tag  = tag_w[0];
    end else begin : g_mid
      assign next_valid = valid_w[i+1];
      assign right_prio = prio_w[i+1];
      assign right_tag  = tag_w[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (valid_w[i]),
      .next_valid_i(next_valid),
      .keep_left_i (keep_left),
      .left_prio_i (left_prio),
      .left_tag_i  (left_tag),
      .right_prio_i(right_prio),
      .right_tag_i (right_tag),
      .head_prio_i (prio_w[0]),
      .head_tag_i  (tag_w[0]),
      .prio_o      (prio_w[i]),
      .tag_o       (tag_w[i]),
      .keep_o      (keep_w[i])
    );
  end

endmodule

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert and
// rotates left during readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
  input  logic                      clk_i,
  input  spq_pkg::chain_cmd_t       cmd_i,
  input  logic                      valid_i,
  input  logic                      next_valid_i,
  input  logic                      keep_left_i,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio_i,
  input  logic [spq_pkg::TAG_W-1:0]  left_tag_i,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio_i,
  input  logic [spq_pkg::TAG_W-1:0]  right_tag_i,
  input  logic [spq_pkg::PRIO_W-1:0] head_prio_i,
  input  logic [spq_pkg::TAG_W-1:0]  head_tag_i,
  output logic [spq_pkg::PRIO_W-1:0] prio_o,
  output logic [spq_pkg::TAG_W-1:0]  tag_o,
  output logic                      keep_o
);
  import spq_pkg::*;

  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic              keep;

  // entry stays ahead of the new one when its priority is equal or higher
  assign keep = valid_i && (prio_q >= cmd_i.prio);

  // next content of the slot
  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    if (cmd_i.insert && !keep) begin
      if (keep_left_i) begin
        prio_d = cmd_i.prio;
        tag_d  = cmd_i.tag;
      end else begin
        prio_d = left_prio_i;
        tag_d  = left_tag_i;
      end
    end else if (cmd_i.rotate) begin
      // head entry wraps around to the tail of the valid run
      if (next_valid_i) begin
        prio_d = right_prio_i;
        tag_d  = right_tag_i;
      end else begin
        prio_d = head_prio_i;
        tag_d  = head_tag_i;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign prio_o = prio_q;
  assign tag_o  = tag_q;
  assign keep_o = keep;

endmodule

// ===== src/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Request handshake, entry count, readout sequencing and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stable_priority_queue_insert_defines.svh"

module spq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [spq_pkg::PRIO_W-1:0]    item_priority_i,
  input  logic [spq_pkg::TAG_W-1:0]     item_tag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority_o,
  output logic [spq_pkg::TAG_W-1:0]     out_tag_o,
  output logic [spq_pkg::STATUS_W-1:0]  status_o,
  output logic                          last_o,
  input  logic [spq_pkg::PRIO_W-1:0]    head_prio_i,
  input  logic [spq_pkg::TAG_W-1:0]     head_tag_i,
  output spq_pkg::chain_cmd_t           cmd_o,
  output logic [spq_pkg::CNT_W-1:0]     cnt_o
);
  import spq_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    rd_q, rd_d;
  logic                out_valid_q, out_valid_d;
  logic [PRIO_W-1:0]   out_prio_q, out_prio_d;
  logic [TAG_W-1:0]    out_tag_q, out_tag_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                last_q, last_d;

  logic out_free;
  logic accept;
  logic full;
  logic rd_last;

  // handshake and status terms
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign rd_last    = ((CNT_W'(rd_q) + CNT_W'(1)) == cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_READOUT) && (cnt_q != '0)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free && rd_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // chain command, count, read index and output word
  always_comb begin
    cmd_o.insert = accept && (req_type_i == REQ_INSERT) && !full;
    cmd_o.rotate = (state_q == ST_READ) && out_free;
    cmd_o.prio   = item_priority_i;
    cmd_o.tag    = item_tag_i;

    cnt_d       = cnt_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q;
    out_prio_d  = out_prio_q;
    out_tag_d   = out_tag_q;
    status_d    = status_q;
    last_d      = last_q;

    if (cmd_o.insert) begin
      cnt_d = cnt_q + CNT_W'(1);
    end

    if (accept) begin
      out_valid_d = 1'b1;
      last_d      = 1'b1;
      if (req_type_i == REQ_INSERT) begin
        out_prio_d = item_priority_i;
        out_tag_d  = item_tag_i;
        status_d   = full ? STATUS_FULL : STATUS_OK;
      end else begin
        out_prio_d = '0;
        out_tag_d  = '0;
        status_d   = (cnt_q == '0) ? STATUS_EMPTY : STATUS_OK;
        // a non-empty readout is streamed from the head cell
        out_valid_d = (cnt_q == '0);
        rd_d        = '0;
      end
    end else if (cmd_o.rotate) begin
      out_valid_d = 1'b1;
      out_prio_d  = head_prio_i;
      out_tag_d   = head_tag_i;
      status_d    = STATUS_OK;
      last_d      = rd_last;
      rd_d        = rd_last ? '0 : rd_q + IDX_W'(1);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_prio_q <= out_prio_d;
    out_tag_q  <= out_tag_d;
    status_q   <= status_d;
    last_q     <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_priority_o = out_prio_q;
  assign out_tag_o      = out_tag_q;
  assign status_o       = status_q;
  assign last_o         = last_q;
  assign cnt_o          = cnt_q;

  // checks
  `SPQ_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `SPQ_ASSERT(a_read_nonempty, (state_q == ST_READ) |-> (CNT_W'(rd_q) < cnt_q), "read index past count")
  `SPQ_ASSERT(a_read_cnt_hold, (state_q == ST_READ) |=> (cnt_q == $past(cnt_q)), "count moved in readout")
  `SPQ_ASSERT(a_insert_grows, (accept && (req_type_i == REQ_INSERT) && !full) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "insert lost")
  `SPQ_ASSERT(a_no_overrun, (out_valid_q && out_stall_i) |-> !accept, "request taken over held word")

endmodule
